### design/mrfc_pkg.sv
// shared types, constants and the crc step for the modbus reply checker
// no dependencies; used by every module of the block
`default_nettype none

package mrfc_pkg;

  localparam int CNT_W         = 6;
  localparam int MAX_FRAME_DEF = 32;
  localparam int HDR_COUNT     = 5;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [CNT_W-1:0] MIN_REPLY_LEN = CNT_W'(7);
  localparam logic [7:0]  MIN_PAYLOAD   = 8'd2;

  localparam logic [7:0] DEV_ADDR_RST = 8'hF8;
  localparam logic [7:0] FUNC_RST     = 8'h04;
  localparam logic [7:0] SCALE_RST    = 8'd10;

  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_FUNC     = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_CRC     = 3'd2,
    ST_ADDR    = 3'd3,
    ST_PAYLOAD = 3'd4
  } mrfc_status_t;

  typedef struct packed {
    mrfc_status_t status;
    logic [15:0]  register_value;
  } mrfc_rec_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/mrfc_front.sv
// front part: accepts reply bytes, keeps crc, count and header, classifies a closed frame
// depends on mrfc_pkg; pushes one record per frame into the queue
`default_nettype none

module mrfc_front #(
  parameter int MAX_FRAME = mrfc_pkg::MAX_FRAME_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_rx_byte,
  input  wire logic                in_has_byte,
  input  wire logic                in_frame_end,
  input  wire logic [7:0]          device_address,
  input  wire logic [7:0]          function_code,
  input  wire logic                q_full,
  output logic                     q_push,
  output mrfc_pkg::mrfc_rec_t      q_rec
);

  localparam int CW = mrfc_pkg::CNT_W;

  logic [CW-1:0] bytes_seen_r, bytes_seen_nxt, cnt_upd;
  logic [15:0]   crc_r, crc_nxt, crc_upd;
  logic [7:0]    hdr_r   [mrfc_pkg::HDR_COUNT];
  logic [7:0]    hdr_nxt [mrfc_pkg::HDR_COUNT];
  logic [7:0]    hdr_upd [mrfc_pkg::HDR_COUNT];
  logic          accept, take_byte, close;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign close    = in_frame_end || !in_has_byte;

  always_comb begin
    take_byte = in_has_byte && (bytes_seen_r < CW'(MAX_FRAME));
    crc_upd   = take_byte ? mrfc_pkg::crc_byte(crc_r, in_rx_byte) : crc_r;
    cnt_upd   = take_byte ? bytes_seen_r + CW'(1) : bytes_seen_r;
    for (int i = 0; i < mrfc_pkg::HDR_COUNT; i++) begin
      hdr_upd[i] = (take_byte && bytes_seen_r == CW'(i)) ? in_rx_byte : hdr_r[i];
    end

    if (cnt_upd < mrfc_pkg::MIN_REPLY_LEN) begin
      q_rec.status = mrfc_pkg::ST_SHORT;
    end else if (crc_upd != 16'h0000) begin
      q_rec.status = mrfc_pkg::ST_CRC;
    end else if (hdr_upd[0] != device_address || hdr_upd[1] != function_code) begin
      q_rec.status = mrfc_pkg::ST_ADDR;
    end else if (hdr_upd[2] < mrfc_pkg::MIN_PAYLOAD) begin
      q_rec.status = mrfc_pkg::ST_PAYLOAD;
    end else begin
      q_rec.status = mrfc_pkg::ST_OK;
    end
    q_rec.register_value = {hdr_upd[3], hdr_upd[4]};
    q_push = accept && close;

    bytes_seen_nxt = bytes_seen_r;
    crc_nxt        = crc_r;
    hdr_nxt        = hdr_r;
    if (accept) begin
      if (close) begin
        bytes_seen_nxt = '0;
        crc_nxt        = mrfc_pkg::CRC_INIT;
        for (int i = 0; i < mrfc_pkg::HDR_COUNT; i++) begin
          hdr_nxt[i] = 8'h00;
        end
      end else begin
        bytes_seen_nxt = cnt_upd;
        crc_nxt        = crc_upd;
        hdr_nxt        = hdr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      crc_r        <= mrfc_pkg::CRC_INIT;
      for (int i = 0; i < mrfc_pkg::HDR_COUNT; i++) begin
        hdr_r[i] <= 8'h00;
      end
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      crc_r        <= crc_nxt;
      hdr_r        <= hdr_nxt;
    end
  end

`ifndef SYNTH
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (bytes_seen_r == '0 && crc_r == mrfc_pkg::CRC_INIT))
    else $error("frame state not cleared after close");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= CW'(MAX_FRAME))
    else $error("byte count above frame limit");
`endif

endmodule

`default_nettype wire

### design/mrfc_queue.sv
// two-entry queue between the front and back parts
// depends on mrfc_pkg for the record type
`default_nettype none

module mrfc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mrfc_pkg::mrfc_rec_t  push_rec,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      not_empty,
  output mrfc_pkg::mrfc_rec_t       head_rec
);

  mrfc_pkg::mrfc_rec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_rec  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2 && ((count_r == 2'd1) == (wr_ptr_r != rd_ptr_r)))
    else $error("queue count and pointers disagree");
`endif

endmodule

`default_nettype wire

### design/mrfc_back.sv
// back part: scales the register word and holds the result until transfer
// depends on mrfc_pkg; reads records from the queue
`default_nettype none

module mrfc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_not_empty,
  input  wire mrfc_pkg::mrfc_rec_t  q_head,
  output logic                      q_pop,
  input  wire logic [7:0]           scale_factor,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_status,
  output logic [15:0]               out_register_value,
  output logic [23:0]               out_scaled_value
);

  logic                  out_valid_r, out_valid_nxt;
  mrfc_pkg::mrfc_status_t status_r;
  logic [15:0]           reg_val_r;
  logic [23:0]           scaled_r, scaled_nxt;

  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = q_pop || (out_valid_r && out_stall);
    if (q_head.status == mrfc_pkg::ST_OK) begin
      scaled_nxt = 24'(q_head.register_value) * 24'(scale_factor);
    end else begin
      scaled_nxt = 24'h000000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r  <= q_head.status;
      reg_val_r <= q_head.register_value;
      scaled_r  <= scaled_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_register_value = reg_val_r;
  assign out_scaled_value   = scaled_r;

`ifndef SYNTH
  a_scaled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != mrfc_pkg::ST_OK) |-> (scaled_r == 24'h000000))
    else $error("scaled value set on a failed frame");
`endif

endmodule

`default_nettype wire

### design/modbus_response_frame_checker_unit.sv
// path: a closing transfer's record is queued, then registered into the out_valid stage
// throughput: one input transfer per cycle; in_stall rises only when both queue
// entries wait behind a stalled output register
// reset: synchronous, active low; frame state back to empty, crc to ffff,
// registers to address f8, function 04, scale 10 (decimal); no clearing pass
// top level: apb register file, front, queue and back; depends on mrfc_pkg
`default_nettype none

module modbus_response_frame_checker_unit #(
  parameter int MAX_FRAME = mrfc_pkg::MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_register_value,
  output logic [23:0]      out_scaled_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] dev_addr_r, func_r, scale_r;
  logic [7:0] dev_addr_nxt, func_nxt, scale_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  logic                q_full, q_push, q_pop, q_not_empty;
  mrfc_pkg::mrfc_rec_t q_rec, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    func_nxt     = func_r;
    scale_nxt    = scale_r;
    if (wr_en) begin
      case (reg_idx)
        mrfc_pkg::REG_DEV_ADDR: dev_addr_nxt = pwdata[7:0];
        mrfc_pkg::REG_FUNC:     func_nxt     = pwdata[7:0];
        mrfc_pkg::REG_SCALE:    scale_nxt    = pwdata[7:0];
        default: ;
      endcase
    end
    case (reg_idx)
      mrfc_pkg::REG_DEV_ADDR: prdata = {24'h0, dev_addr_r};
      mrfc_pkg::REG_FUNC:     prdata = {24'h0, func_r};
      mrfc_pkg::REG_SCALE:    prdata = {24'h0, scale_r};
      default:                prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= mrfc_pkg::DEV_ADDR_RST;
      func_r     <= mrfc_pkg::FUNC_RST;
      scale_r    <= mrfc_pkg::SCALE_RST;
    end else begin
      dev_addr_r <= dev_addr_nxt;
      func_r     <= func_nxt;
      scale_r    <= scale_nxt;
    end
  end

  mrfc_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_has_byte   (in_has_byte),
    .in_frame_end  (in_frame_end),
    .device_address(dev_addr_r),
    .function_code (func_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_rec         (q_rec)
  );

  mrfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_rec (q_head)
  );

  mrfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .scale_factor      (scale_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_register_value(out_register_value),
    .out_scaled_value  (out_scaled_value)
  );

endmodule

`default_nettype wire
